// ===== sv/tmcs_pkg.sv =====
// ============================================================================
// tmcs_pkg
// Shared types and constants for the texture mip chain size block.
// ============================================================================
package tmcs_pkg;

  localparam int unsigned FMT_W   = 4;
  localparam int unsigned DIM_W   = 15;
  localparam int unsigned CNT_W   = 12;
  localparam int unsigned LVLIN_W = 4;
  localparam int unsigned TOTAL_W = 55;

  // Shared multiplier: covers w x h (15 x 15), layers x depth (12 x 12)
  // and (w x h) x (layers x depth) (30 x 24).
  localparam int unsigned MUL_A_W = 30;
  localparam int unsigned MUL_B_W = 24;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // The bytes-per-unit shift adds at most four bits to the product.
  localparam int unsigned SUM_W = MUL_P_W + 5;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  localparam logic [FMT_W-1:0] FMT_RGBA8  = 4'd0;
  localparam logic [FMT_W-1:0] FMT_RGBA8S = 4'd1;
  localparam logic [FMT_W-1:0] FMT_RGBA16F = 4'd2;
  localparam logic [FMT_W-1:0] FMT_RGBA32F = 4'd3;
  localparam logic [FMT_W-1:0] FMT_R8     = 4'd4;
  localparam logic [FMT_W-1:0] FMT_RG8    = 4'd5;
  localparam logic [FMT_W-1:0] FMT_D32F   = 4'd6;
  localparam logic [FMT_W-1:0] FMT_D24S8  = 4'd7;
  localparam logic [FMT_W-1:0] FMT_BC1    = 4'd8;
  localparam logic [FMT_W-1:0] FMT_BC3    = 4'd9;
  localparam logic [FMT_W-1:0] FMT_BC5    = 4'd10;
  localparam logic [FMT_W-1:0] FMT_BC7    = 4'd11;

  typedef struct packed {
    logic       compressed;
    logic [2:0] shift;
  } fmt_info_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LD   = 6'b000010,
    ST_WH   = 6'b000100,
    ST_TERM = 6'b001000,
    ST_ACC  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  // Bytes per pixel, or per 4x4 block for compressed formats, as log2.
  function automatic fmt_info_t fmt_decode(input logic [FMT_W-1:0] fmt);
    fmt_info_t info;
    info.compressed = 1'b0;
    info.shift      = 3'd2;
    unique case (fmt)
      FMT_RGBA16F: info.shift = 3'd3;
      FMT_RGBA32F: info.shift = 3'd4;
      FMT_R8:      info.shift = 3'd0;
      FMT_RG8:     info.shift = 3'd1;
      FMT_BC1: begin
        info.compressed = 1'b1;
        info.shift      = 3'd3;
      end
      FMT_BC3, FMT_BC5, FMT_BC7: begin
        info.compressed = 1'b1;
        info.shift      = 3'd4;
      end
      default: info.shift = 3'd2;
    endcase
    return info;
  endfunction

endpackage

// ===== sv/tmcs_mul.sv =====
// ============================================================================
// tmcs_mul
// Shared registered multiplier used for every product in the mip chain sum.
// ============================================================================
module tmcs_mul
  import tmcs_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] p
);

  logic [MUL_P_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= MUL_P_W'(a) * MUL_P_W'(b);
    end
  end

  assign p = p_r;

endmodule

// ===== sv/texture_mip_chain_size.sv =====
// ============================================================================
// texture_mip_chain_size
// Total byte size of a texture over its mip chain, layers and depth slices.
// ============================================================================
// One texture description is taken at a time and one total comes back. The
// result word is valid once the last of L mip levels has been accumulated,
// where L is level_count clamped to MAX_LEVELS. Layers x depth is formed
// first, then each mip level takes width x height and that product times
// layers x depth on the single shared multiplier, then a shift-and-saturating
// accumulate. A count of zero levels answers on the cycle after acceptance.
// The input is stalled from acceptance until the result word has been taken.
module texture_mip_chain_size
  import tmcs_pkg::*;
#(
  parameter int unsigned MAX_LEVELS = 15
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FMT_W-1:0]   in_pixel_format,
  input  logic [DIM_W-1:0]   in_base_width,
  input  logic [DIM_W-1:0]   in_base_height,
  input  logic [CNT_W-1:0]   in_slice_depth,
  input  logic [LVLIN_W-1:0] in_level_count,
  input  logic [CNT_W-1:0]   in_layer_count,

  output logic               out_valid,
  input  logic               out_stall,
  output logic [TOTAL_W-1:0] out_total_bytes
);

  localparam int unsigned LVL_W = $clog2(MAX_LEVELS + 1);

  state_t             state_r, state_nxt;
  logic               out_valid_r;
  logic               first_r;
  logic [LVL_W-1:0]   lvl_r;
  logic [DIM_W-1:0]   w_r, h_r;
  logic [CNT_W-1:0]   depth_r, layers_r;
  fmt_info_t          fmt_r;
  logic [MUL_B_W-1:0] ld_r;
  logic [TOTAL_W-1:0] total_r;

  logic               in_acc;
  logic               out_acc;
  logic [4:0]         lc_ext;
  logic [4:0]         lc_clamp;
  logic [DIM_W-2:0]   wb, hb;
  logic [DIM_W-1:0]   w_op, h_op;
  logic               mul_en;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;
  logic [SUM_W-1:0]   term_sh;
  logic [SUM_W-1:0]   sum;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;

  assign lc_ext   = 5'(in_level_count);
  assign lc_clamp = (lc_ext > 5'(MAX_LEVELS)) ? 5'(MAX_LEVELS) : lc_ext;

  // Compressed formats count 4x4 blocks, rounded up.
  assign wb   = (DIM_W-1)'((DIM_W+1)'(w_r) + (DIM_W+1)'(3) >> 2);
  assign hb   = (DIM_W-1)'((DIM_W+1)'(h_r) + (DIM_W+1)'(3) >> 2);
  assign w_op = fmt_r.compressed ? DIM_W'(wb) : w_r;
  assign h_op = fmt_r.compressed ? DIM_W'(hb) : h_r;

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_r)
      ST_LD: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(layers_r);
        mul_b  = MUL_B_W'(depth_r);
      end
      ST_WH: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(w_op);
        mul_b  = MUL_B_W'(h_op);
      end
      ST_TERM: begin
        mul_en = 1'b1;
        mul_a  = prod[MUL_A_W-1:0];
        mul_b  = ld_r;
      end
      default: mul_en = 1'b0;
    endcase
  end

  tmcs_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign term_sh = SUM_W'(prod) << fmt_r.shift;
  assign sum     = SUM_W'(total_r) + term_sh;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (lc_clamp == 5'd0) ? ST_DONE : ST_LD;
        end
      end
      ST_LD:   state_nxt = ST_WH;
      ST_WH:   state_nxt = ST_TERM;
      ST_TERM: state_nxt = ST_ACC;
      ST_ACC:  state_nxt = (lvl_r == LVL_W'(1)) ? ST_DONE : ST_WH;
      ST_DONE: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_acc) begin
        out_valid_r <= 1'b0;
      end else if (state_nxt == ST_DONE && state_r != ST_DONE) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      fmt_r    <= fmt_decode(in_pixel_format);
      w_r      <= in_base_width;
      h_r      <= in_base_height;
      depth_r  <= in_slice_depth;
      layers_r <= in_layer_count;
      lvl_r    <= lc_clamp[LVL_W-1:0];
      total_r  <= '0;
      first_r  <= 1'b1;
    end else begin
      // On the first level pass the product register still holds layers x depth.
      if (state_r == ST_WH && first_r) begin
        ld_r    <= prod[MUL_B_W-1:0];
        first_r <= 1'b0;
      end
      if (state_r == ST_ACC) begin
        total_r <= (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        w_r     <= (w_r > DIM_W'(1)) ? (w_r >> 1) : DIM_W'(1);
        h_r     <= (h_r > DIM_W'(1)) ? (h_r >> 1) : DIM_W'(1);
        lvl_r   <= lvl_r - LVL_W'(1);
      end
    end
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_total_bytes = total_r;

  a_valid_in_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r == (state_r == ST_DONE))
    else $error("result word valid outside the done state");

  a_acc_levels_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC) |-> (lvl_r != '0))
    else $error("accumulate with no level left");

  a_zero_levels: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_level_count == '0) |=> (state_r == ST_DONE && total_r == '0))
    else $error("zero level count did not answer zero at once");

  a_clear_total: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LD) |-> (total_r == '0 && first_r))
    else $error("sum not cleared at start of item");

endmodule
